FILE: rtl/mjp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjp_pkg
// Shared types and constants of the multi-joint PID regulator: field widths,
// register indexes and reset values, controller states, datapath commands.
// ----------------------------------------------------------------------------
package mjp_pkg;

    // fixed point format and field widths
    localparam int FRAC_W    = 16;
    localparam int JSEL_W    = 3;
    localparam int ANG_IN_W  = 20;
    localparam int VAL_W     = 32;
    localparam int INT_W     = 48;
    localparam int GAIN_W    = 24;
    localparam int DT_W      = 17;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 3'd4;

    // register reset values, unsigned Q8.16 (dt Q1.16)
    localparam logic [GAIN_W-1:0] RST_KP   = 24'd655360;
    localparam logic [GAIN_W-1:0] RST_KI   = 24'd6554;
    localparam logic [GAIN_W-1:0] RST_KD   = 24'd65536;
    localparam logic [DT_W-1:0]   RST_DT   = 17'd655;
    localparam logic [GAIN_W-1:0] RST_RATE = 24'd6553600;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_PLO,
        S_PHI,
        S_RND,
        S_WRITE,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_FETCH,
        OP_LOAD,
        OP_PLO,
        OP_PHI,
        OP_RND,
        OP_WRITE,
        OP_EMIT
    } dp_op_t;

    // one product per step, in dependency order
    typedef enum logic [2:0] {
        STEP_INC,
        STEP_DERIV,
        STEP_PROP,
        STEP_INTEG,
        STEP_DIFF,
        STEP_MOVE
    } step_t;

    typedef struct packed {
        dp_op_t op;
        step_t  step;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_preset;
        logic hist_valid;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/mjp_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjp_controller
// Sequencer of the PID regulator: takes one beat at a time, walks up to six
// products through the shared multiplier and hands the result to the output.
// ----------------------------------------------------------------------------
module mjp_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mjp_pkg::status_t status,
    output mjp_pkg::cmd_t    cmd
);

    mjp_pkg::ctrl_state_t state_reg, state_next;
    mjp_pkg::step_t       step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mjp_pkg::S_IDLE;
            step_reg  <= mjp_pkg::STEP_INC;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = mjp_pkg::OP_NONE;
        cmd.step   = step_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            mjp_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = mjp_pkg::OP_CAPTURE;
                    state_next = mjp_pkg::S_FETCH;
                end
            end
            mjp_pkg::S_FETCH: begin
                cmd.op = mjp_pkg::OP_FETCH;
                if (!status.in_range || status.is_preset) begin
                    state_next = mjp_pkg::S_EMIT;
                end else begin
                    state_next = mjp_pkg::S_LOAD;
                    step_next  = mjp_pkg::STEP_INC;
                end
            end
            mjp_pkg::S_LOAD: begin
                cmd.op     = mjp_pkg::OP_LOAD;
                state_next = mjp_pkg::S_PLO;
            end
            mjp_pkg::S_PLO: begin
                cmd.op     = mjp_pkg::OP_PLO;
                state_next = mjp_pkg::S_PHI;
            end
            mjp_pkg::S_PHI: begin
                cmd.op     = mjp_pkg::OP_PHI;
                state_next = mjp_pkg::S_RND;
            end
            mjp_pkg::S_RND: begin
                cmd.op     = mjp_pkg::OP_RND;
                state_next = mjp_pkg::S_WRITE;
            end
            mjp_pkg::S_WRITE: begin
                cmd.op     = mjp_pkg::OP_WRITE;
                state_next = mjp_pkg::S_LOAD;
                unique case (step_reg)
                    mjp_pkg::STEP_INC: begin
                        // no derivative on the first step of a joint
                        step_next = status.hist_valid ? mjp_pkg::STEP_DERIV
                                                      : mjp_pkg::STEP_PROP;
                    end
                    mjp_pkg::STEP_DERIV: step_next = mjp_pkg::STEP_PROP;
                    mjp_pkg::STEP_PROP:  step_next = mjp_pkg::STEP_INTEG;
                    mjp_pkg::STEP_INTEG: step_next = mjp_pkg::STEP_DIFF;
                    mjp_pkg::STEP_DIFF:  step_next = mjp_pkg::STEP_MOVE;
                    mjp_pkg::STEP_MOVE:  state_next = mjp_pkg::S_EMIT;
                    default:             state_next = mjp_pkg::S_EMIT;
                endcase
            end
            mjp_pkg::S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = mjp_pkg::OP_EMIT;
                    state_next = mjp_pkg::S_IDLE;
                end
            end
            default: state_next = mjp_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: rtl/mjp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjp_datapath
// Joint state, gain registers, shared two-pass 24x24 multiplier with
// rounding and saturation, and the output register of the PID regulator.
// ----------------------------------------------------------------------------
module mjp_datapath #(
    parameter int JOINTS = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mjp_pkg::cmd_t                         cmd,
    output mjp_pkg::status_t                      status,
    input  logic                                  cfg_wr_en,
    input  logic [mjp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mjp_pkg::GAIN_W-1:0]            cfg_wr_data,
    input  logic                                  s_req_type,
    input  logic [mjp_pkg::JSEL_W-1:0]            s_joint_select,
    input  logic signed [mjp_pkg::ANG_IN_W-1:0]   s_angle_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mjp_pkg::JSEL_W-1:0]            m_joint_echo,
    output logic signed [mjp_pkg::VAL_W-1:0]      m_drive_velocity,
    output logic signed [mjp_pkg::VAL_W-1:0]      m_joint_angle,
    output logic                                  m_saturated
);

    localparam int VAL_W   = mjp_pkg::VAL_W;
    localparam int INT_W   = mjp_pkg::INT_W;
    localparam int GAIN_W  = mjp_pkg::GAIN_W;
    localparam int FRAC_W  = mjp_pkg::FRAC_W;
    localparam int JSEL_W  = mjp_pkg::JSEL_W;
    localparam int ANG_W   = mjp_pkg::ANG_IN_W;
    localparam int MAG_W   = INT_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int PP_W    = HALF_W + GAIN_W;
    localparam int FULL_W  = MAG_W + GAIN_W;
    localparam int RMAG_W  = FULL_W - FRAC_W;
    localparam int SUM_W   = INT_W + 2;
    localparam int ACC_W   = VAL_W + 2;
    localparam int JIDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int SELX_W  = (JIDX_W > JSEL_W) ? JIDX_W : JSEL_W;
    localparam logic [FULL_W-1:0] RND_HALF = FULL_W'(1) << (FRAC_W - 1);

    typedef struct packed {
        logic signed [INT_W-1:0] v;
        logic                    sat;
    } sval_t;

    // rounded magnitude and sign to a signed value of 32 or 48 bits
    function automatic sval_t mag_clip(input logic neg, input logic [RMAG_W-1:0] mag,
                                       input logic wide);
        logic [RMAG_W-1:0] lim;
        logic [RMAG_W-1:0] magc;
        logic [INT_W-1:0]  m;
        sval_t             r;
        lim = wide ? (RMAG_W'(1) << (INT_W - 1)) : (RMAG_W'(1) << (VAL_W - 1));
        if (!neg) begin
            lim = lim - RMAG_W'(1);
        end
        r.sat = mag > lim;
        magc  = r.sat ? lim : mag;
        m     = magc[INT_W-1:0];
        r.v   = neg ? (~m + INT_W'(1)) : m;
        return r;
    endfunction

    function automatic sval_t clip_sum(input logic signed [SUM_W-1:0] x, input logic wide);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        sval_t                   r;
        hi = wide ? {{(SUM_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}}
                  : {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        lo = ~hi;
        r.sat = (x > hi) || (x < lo);
        if (x > hi) begin
            r.v = hi[INT_W-1:0];
        end else if (x < lo) begin
            r.v = lo[INT_W-1:0];
        end else begin
            r.v = x[INT_W-1:0];
        end
        return r;
    endfunction

    // gain registers
    logic [GAIN_W-1:0]      kp_reg, ki_reg, kd_reg, rate_reg;
    logic [mjp_pkg::DT_W-1:0] dt_reg;

    // joint state
    logic signed [VAL_W-1:0] angle_mem_reg [JOINTS];
    logic signed [INT_W-1:0] integ_mem_reg [JOINTS];
    logic signed [VAL_W-1:0] lerr_mem_reg  [JOINTS];
    logic [JOINTS-1:0]       hv_reg;

    // working registers of the current beat
    logic                    kind_reg;
    logic [JSEL_W-1:0]       sel_reg;
    logic signed [ANG_W-1:0] target_reg;
    logic signed [VAL_W-1:0] angle_w_reg;
    logic signed [INT_W-1:0] integ_reg;
    logic signed [VAL_W-1:0] lerr_reg;
    logic                    hv_w_reg;
    logic signed [VAL_W-1:0] err_reg;
    logic signed [VAL_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] vel_reg;
    logic signed [VAL_W-1:0] ang_reg;
    logic                    sat_reg;

    // multiplier pipeline
    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [PP_W-1:0]   plo_reg, phi_reg;
    logic [RMAG_W-1:0] rmag_reg;
    logic              rneg_reg;

    // output register
    logic                    m_valid_reg;
    logic [JSEL_W-1:0]       echo_reg;
    logic signed [VAL_W-1:0] vel_out_reg, ang_out_reg;
    logic                    sat_out_reg;

    logic [SELX_W-1:0]       sel_ext;
    logic [JIDX_W-1:0]       jidx;
    logic                    in_range;
    logic signed [VAL_W-1:0] target_ext;
    logic signed [MAG_W:0]   opnd;
    logic [MAG_W:0]          opnd_neg;
    logic [GAIN_W-1:0]       gain_sel;
    logic [FULL_W-1:0]       full;
    sval_t                   mres;
    logic signed [SUM_W-1:0] term, base, wsum, fsum;
    sval_t                   wclip, fclip;

    assign sel_ext    = SELX_W'(sel_reg);
    assign jidx       = sel_ext[JIDX_W-1:0];
    assign in_range   = 32'(sel_reg) < 32'(JOINTS);
    assign target_ext = {{(VAL_W-ANG_W){target_reg[ANG_W-1]}}, target_reg};

    assign status.in_range   = in_range;
    assign status.is_preset  = kind_reg;
    assign status.hist_valid = hv_w_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    // operand and gain of each product
    always_comb begin
        unique case (cmd.step)
            mjp_pkg::STEP_INC: begin
                opnd     = {{(MAG_W+1-VAL_W){err_reg[VAL_W-1]}}, err_reg};
                gain_sel = GAIN_W'(dt_reg);
            end
            mjp_pkg::STEP_DERIV: begin
                opnd     = {{(MAG_W+1-VAL_W){err_reg[VAL_W-1]}}, err_reg}
                         - {{(MAG_W+1-VAL_W){lerr_reg[VAL_W-1]}}, lerr_reg};
                gain_sel = rate_reg;
            end
            mjp_pkg::STEP_PROP: begin
                opnd     = {{(MAG_W+1-VAL_W){err_reg[VAL_W-1]}}, err_reg};
                gain_sel = kp_reg;
            end
            mjp_pkg::STEP_INTEG: begin
                opnd     = {integ_reg[INT_W-1], integ_reg};
                gain_sel = ki_reg;
            end
            mjp_pkg::STEP_DIFF: begin
                opnd     = {{(MAG_W+1-VAL_W){deriv_reg[VAL_W-1]}}, deriv_reg};
                gain_sel = kd_reg;
            end
            mjp_pkg::STEP_MOVE: begin
                opnd     = {{(MAG_W+1-VAL_W){vel_reg[VAL_W-1]}}, vel_reg};
                gain_sel = GAIN_W'(dt_reg);
            end
            default: begin
                opnd     = '0;
                gain_sel = '0;
            end
        endcase
        opnd_neg = -opnd;
    end

    assign full = {phi_reg, HALF_W'(0)} + FULL_W'(plo_reg) + RND_HALF;

    // clipped product and the sum it feeds
    always_comb begin
        mres = mag_clip(rneg_reg, rmag_reg, cmd.step == mjp_pkg::STEP_INC);
        term = {{(SUM_W-INT_W){mres.v[INT_W-1]}}, mres.v};
        case (cmd.step) inside
            mjp_pkg::STEP_INC:   base = {{(SUM_W-INT_W){integ_reg[INT_W-1]}}, integ_reg};
            mjp_pkg::STEP_INTEG,
            mjp_pkg::STEP_DIFF:  base = {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
            mjp_pkg::STEP_MOVE:  base = {{(SUM_W-VAL_W){angle_w_reg[VAL_W-1]}}, angle_w_reg};
            default:             base = '0;
        endcase
        wsum  = base + term;
        wclip = clip_sum(wsum, cmd.step == mjp_pkg::STEP_INC);
        fsum  = {{(SUM_W-VAL_W){target_ext[VAL_W-1]}}, target_ext}
              - {{(SUM_W-VAL_W){angle_mem_reg[jidx][VAL_W-1]}}, angle_mem_reg[jidx]};
        fclip = clip_sum(fsum, 1'b0);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= mjp_pkg::RST_KP;
            ki_reg   <= mjp_pkg::RST_KI;
            kd_reg   <= mjp_pkg::RST_KD;
            dt_reg   <= mjp_pkg::RST_DT;
            rate_reg <= mjp_pkg::RST_RATE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mjp_pkg::CFG_KP:   kp_reg   <= cfg_wr_data;
                mjp_pkg::CFG_KI:   ki_reg   <= cfg_wr_data;
                mjp_pkg::CFG_KD:   kd_reg   <= cfg_wr_data;
                mjp_pkg::CFG_DT:   dt_reg   <= cfg_wr_data[mjp_pkg::DT_W-1:0];
                mjp_pkg::CFG_RATE: rate_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // joint state: preset at fetch, write back after the angle update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < JOINTS; j++) begin
                angle_mem_reg[j] <= '0;
                integ_mem_reg[j] <= '0;
                lerr_mem_reg[j]  <= '0;
            end
            hv_reg <= '0;
        end else if (cmd.op == mjp_pkg::OP_FETCH && in_range && kind_reg) begin
            angle_mem_reg[jidx] <= target_ext;
            integ_mem_reg[jidx] <= '0;
            lerr_mem_reg[jidx]  <= '0;
            hv_reg[jidx]        <= 1'b0;
        end else if (cmd.op == mjp_pkg::OP_WRITE && cmd.step == mjp_pkg::STEP_MOVE) begin
            angle_mem_reg[jidx] <= wclip.v[VAL_W-1:0];
            integ_mem_reg[jidx] <= integ_reg;
            lerr_mem_reg[jidx]  <= err_reg;
            hv_reg[jidx]        <= 1'b1;
        end
    end

    // working registers and multiplier
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            mjp_pkg::OP_CAPTURE: begin
                kind_reg   <= s_req_type;
                sel_reg    <= s_joint_select;
                target_reg <= s_angle_value;
                sat_reg    <= 1'b0;
            end
            mjp_pkg::OP_FETCH: begin
                if (!in_range) begin
                    vel_reg <= '0;
                    ang_reg <= '0;
                end else if (kind_reg) begin
                    vel_reg <= '0;
                    ang_reg <= target_ext;
                end else begin
                    angle_w_reg <= angle_mem_reg[jidx];
                    integ_reg   <= integ_mem_reg[jidx];
                    lerr_reg    <= lerr_mem_reg[jidx];
                    hv_w_reg    <= hv_reg[jidx];
                    err_reg     <= fclip.v[VAL_W-1:0];
                    sat_reg     <= fclip.sat;
                    deriv_reg   <= '0;
                end
            end
            mjp_pkg::OP_LOAD: begin
                neg_reg  <= opnd[MAG_W];
                mag_reg  <= opnd[MAG_W] ? opnd_neg[MAG_W-1:0] : opnd[MAG_W-1:0];
                gain_reg <= gain_sel;
            end
            mjp_pkg::OP_PLO: plo_reg <= mag_reg[HALF_W-1:0] * gain_reg;
            mjp_pkg::OP_PHI: phi_reg <= mag_reg[MAG_W-1:HALF_W] * gain_reg;
            mjp_pkg::OP_RND: begin
                rmag_reg <= full[FULL_W-1:FRAC_W];
                rneg_reg <= neg_reg;
            end
            mjp_pkg::OP_WRITE: begin
                case (cmd.step)
                    mjp_pkg::STEP_INC: begin
                        integ_reg <= wclip.v;
                        sat_reg   <= sat_reg | mres.sat | wclip.sat;
                    end
                    mjp_pkg::STEP_DERIV: begin
                        deriv_reg <= mres.v[VAL_W-1:0];
                        sat_reg   <= sat_reg | mres.sat;
                    end
                    mjp_pkg::STEP_PROP: begin
                        acc_reg <= term[ACC_W-1:0];
                        sat_reg <= sat_reg | mres.sat;
                    end
                    mjp_pkg::STEP_INTEG: begin
                        acc_reg <= wsum[ACC_W-1:0];
                        sat_reg <= sat_reg | mres.sat;
                    end
                    mjp_pkg::STEP_DIFF: begin
                        vel_reg <= wclip.v[VAL_W-1:0];
                        sat_reg <= sat_reg | mres.sat | wclip.sat;
                    end
                    mjp_pkg::STEP_MOVE: begin
                        ang_reg <= wclip.v[VAL_W-1:0];
                        sat_reg <= sat_reg | mres.sat | wclip.sat;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == mjp_pkg::OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == mjp_pkg::OP_EMIT) begin
            echo_reg    <= sel_reg;
            vel_out_reg <= vel_reg;
            ang_out_reg <= ang_reg;
            sat_out_reg <= sat_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_joint_echo     = echo_reg;
    assign m_drive_velocity = vel_out_reg;
    assign m_joint_angle    = ang_out_reg;
    assign m_saturated      = sat_out_reg;

endmodule

FILE: rtl/multi_joint_pid_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_joint_pid_axis
// Work: a control step walks up to six products, in sequence, through the
//   one 24x24 multiplier, two passes each; no derivative on the first step
//   of a joint after reset or preset; a preset or unknown joint skips them.
// One beat at a time: a new beat is only taken once the result is emitted.
// Reset: synchronous active low; clears all joint angles, integrals and
//   history and loads the default gains, dt and 1/dt.
// ----------------------------------------------------------------------------
module multi_joint_pid_axis #(
    parameter int JOINTS = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mjp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mjp_pkg::GAIN_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [mjp_pkg::JSEL_W-1:0]            s_joint_select,
    input  logic signed [mjp_pkg::ANG_IN_W-1:0]   s_angle_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mjp_pkg::JSEL_W-1:0]            m_joint_echo,
    output logic signed [mjp_pkg::VAL_W-1:0]      m_drive_velocity,
    output logic signed [mjp_pkg::VAL_W-1:0]      m_joint_angle,
    output logic                                  m_saturated
);

    mjp_pkg::cmd_t    cmd;
    mjp_pkg::status_t status;

    mjp_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mjp_datapath #(
        .JOINTS (JOINTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_req_type       (s_req_type),
        .s_joint_select   (s_joint_select),
        .s_angle_value    (s_angle_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_joint_echo     (m_joint_echo),
        .m_drive_velocity (m_drive_velocity),
        .m_joint_angle    (m_joint_angle),
        .m_saturated      (m_saturated)
    );

    // one beat in flight: no second accept right after the first
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // unknown joint gives an all-zero result
    a_unknown_joint: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (32'(m_joint_echo) >= 32'(JOINTS)))
        |-> (m_drive_velocity == '0 && m_joint_angle == '0 && !m_saturated))
        else $error("nonzero result for unknown joint");

    // a result only appears at the end of a beat's work
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while idle");

endmodule

FILE: tb/multi_joint_pid_axis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_joint_pid_axis_test
// Self-checking bench for the shared six-joint PID regulator. A table of
// directed beats covers presets, unknown joints, first steps and the angle
// extremes. Random beats then run under several gain and dt settings, from
// all zero to all ones. Every result is checked field by field against the
// table row or a Q16.16 PID predictor that keeps its own per-joint angle,
// integral and error history. Both handshakes idle at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module multi_joint_pid_axis_test;

    import mjp_pkg::*;

    localparam int JOINTS       = 6;
    localparam int ANG_LIMIT    = 411775;
    localparam int PHASE_ITEMS  = 204;
    localparam int TAIL_CYCLES  = 40;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic REQ_STEP   = 1'b0;
    localparam logic REQ_PRESET = 1'b1;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [JSEL_W-1:0]       joint;
        logic signed [VAL_W-1:0] velocity;
        logic signed [VAL_W-1:0] angle;
        logic                    clipped;
    } joint_update_t;

    typedef struct packed {
        logic                       req;
        logic [JSEL_W-1:0]          joint;
        logic signed [ANG_IN_W-1:0] ang;
        logic                       known;
        joint_update_t              want;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    // rows with known set carry a result that follows directly from the spec
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{REQ_PRESET, 3'd0,  20'sd411775, 1'b1, '{3'd0, 32'sd0,  32'sd411775, 1'b0}},
        '{REQ_PRESET, 3'd1, -20'sd411775, 1'b1, '{3'd1, 32'sd0, -32'sd411775, 1'b0}},
        '{REQ_STEP,   3'd6,  20'sd1000,   1'b1, '{3'd6, 32'sd0,  32'sd0,      1'b0}},
        '{REQ_PRESET, 3'd7, -20'sd5,      1'b1, '{3'd7, 32'sd0,  32'sd0,      1'b0}},
        '{REQ_STEP,   3'd2,  20'sd0,      1'b1, '{3'd2, 32'sd0,  32'sd0,      1'b0}},
        '{REQ_STEP,   3'd0,  20'sd411775, 1'b1, '{3'd0, 32'sd0,  32'sd411775, 1'b0}},
        '{REQ_STEP,   3'd3,  20'sd65536,  1'b0, '0},
        '{REQ_STEP,   3'd3,  20'sd65536,  1'b0, '0},
        '{REQ_STEP,   3'd3, -20'sd524288, 1'b0, '0},
        '{REQ_STEP,   3'd3,  20'sd524287, 1'b0, '0},
        '{REQ_STEP,   3'd1,  20'sd411775, 1'b0, '0},
        '{REQ_STEP,   3'd1,  20'sd411775, 1'b0, '0},
        '{REQ_STEP,   3'd1, -20'sd411775, 1'b0, '0},
        '{REQ_PRESET, 3'd3, -20'sd524288, 1'b1, '{3'd3, 32'sd0, -32'sd524288, 1'b0}},
        '{REQ_STEP,   3'd3,  20'sd524287, 1'b0, '0},
        '{REQ_STEP,   3'd3,  20'sd524287, 1'b0, '0},
        '{REQ_PRESET, 3'd5,  20'sd524287, 1'b1, '{3'd5, 32'sd0,  32'sd524287, 1'b0}},
        '{REQ_STEP,   3'd5, -20'sd524288, 1'b0, '0},
        '{REQ_STEP,   3'd4, -20'sd1,      1'b0, '0},
        '{REQ_STEP,   3'd7,  20'sd524287, 1'b1, '{3'd7, 32'sd0,  32'sd0,      1'b0}},
        '{REQ_PRESET, 3'd6,  20'sd524287, 1'b1, '{3'd6, 32'sd0,  32'sd0,      1'b0}},
        '{REQ_STEP,   3'd5, -20'sd524288, 1'b0, '0}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [GAIN_W-1:0]          cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_req_type;
    logic [JSEL_W-1:0]          s_joint_select;
    logic signed [ANG_IN_W-1:0] s_angle_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [JSEL_W-1:0]          m_joint_echo;
    logic signed [VAL_W-1:0]    m_drive_velocity;
    logic signed [VAL_W-1:0]    m_joint_angle;
    logic                       m_saturated;

    // predictor copy of the registers and the per-joint state
    longint unsigned gain_p   = RST_KP;
    longint unsigned gain_i   = RST_KI;
    longint unsigned gain_d   = RST_KD;
    longint unsigned dt_val   = RST_DT;
    longint unsigned rate_val = RST_RATE;

    longint joint_pos   [JOINTS] = '{default: 0};
    longint joint_integ [JOINTS] = '{default: 0};
    longint joint_err   [JOINTS] = '{default: 0};
    bit     joint_hist  [JOINTS] = '{default: 0};

    logic signed [ANG_IN_W-1:0] aim [JOINTS] = '{default: 0};

    joint_update_t pending_updates [$];
    bit            clip_flag;
    int            idle_mode;
    int            beats_out;
    int            error_count;
    bit            held_off;

    always #1 aclk = ~aclk;

    multi_joint_pid_axis #(
        .JOINTS(JOINTS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_joint_select   (s_joint_select),
        .s_angle_value    (s_angle_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_joint_echo     (m_joint_echo),
        .m_drive_velocity (m_drive_velocity),
        .m_joint_angle    (m_joint_angle),
        .m_saturated      (m_saturated)
    );

    function automatic longint clip_to(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            clip_flag = 1'b1;
            return hi;
        end
        if (x < lo) begin
            clip_flag = 1'b1;
            return lo;
        end
        return x;
    endfunction

    // (v * g) >> FRAC_W, rounded half away from zero, clipped to bits
    function automatic longint scale_mul(input longint v, input longint unsigned g,
                                         input int bits);
        bit              neg;
        longint unsigned mag;
        longint unsigned p_hi;
        longint unsigned p_lo;
        longint unsigned res;
        longint unsigned pos_max;
        longint unsigned neg_max;
        neg     = v < 0;
        mag     = neg ? -v : v;
        p_hi    = (mag >> 24) * g;
        p_lo    = (mag & 64'hFF_FFFF) * g;
        pos_max = (64'd1 << (bits - 1)) - 1;
        neg_max = 64'd1 << (bits - 1);
        if ((p_hi >> 39) != 0) begin
            clip_flag = 1'b1;
            return neg ? -longint'(neg_max) : longint'(pos_max);
        end
        res = ((p_hi << 24) + p_lo + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        if (neg) begin
            if (res > neg_max) begin
                clip_flag = 1'b1;
                res = neg_max;
            end
            return -longint'(res);
        end
        if (res > pos_max) begin
            clip_flag = 1'b1;
            res = pos_max;
        end
        return longint'(res);
    endfunction

    function automatic joint_update_t pid_advance(input logic req,
                                                  input logic [JSEL_W-1:0] jsel,
                                                  input logic signed [ANG_IN_W-1:0] ang);
        joint_update_t r;
        longint target;
        longint err;
        longint inc;
        longint integ;
        longint deriv;
        longint tp;
        longint ti;
        longint td;
        longint vel;
        longint move;
        longint pos;
        int     j;
        clip_flag  = 1'b0;
        target     = ang;
        r.joint    = jsel;
        r.velocity = '0;
        r.angle    = '0;
        if (jsel < JOINTS) begin
            j = jsel;
            if (req == REQ_PRESET) begin
                joint_pos[j]   = target;
                joint_integ[j] = 0;
                joint_err[j]   = 0;
                joint_hist[j]  = 1'b0;
                r.angle        = target[VAL_W-1:0];
            end else begin
                err   = clip_to(target - joint_pos[j], VAL_W);
                inc   = scale_mul(err, dt_val, INT_W);
                integ = clip_to(joint_integ[j] + inc, INT_W);
                deriv = 0;
                if (joint_hist[j])
                    deriv = scale_mul(err - joint_err[j], rate_val, VAL_W);
                tp   = scale_mul(err, gain_p, VAL_W);
                ti   = scale_mul(integ, gain_i, VAL_W);
                td   = scale_mul(deriv, gain_d, VAL_W);
                vel  = clip_to(tp + ti + td, VAL_W);
                move = scale_mul(vel, dt_val, VAL_W);
                pos  = clip_to(joint_pos[j] + move, VAL_W);
                joint_integ[j] = integ;
                joint_err[j]   = err;
                joint_hist[j]  = 1'b1;
                joint_pos[j]   = pos;
                r.velocity     = vel[VAL_W-1:0];
                r.angle        = pos[VAL_W-1:0];
            end
        end
        r.clipped = clip_flag;
        return r;
    endfunction

    // mostly short gaps, a few long ones; mode 0 means no idling at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0)
            return 0;
        if (idle_mode == 1) begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
        if (r < 30)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        if ($urandom_range(0, 3) == 0)
            return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(0, 24'h0F_FFFF));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            CFG_KP:   gain_p = data;
            CFG_KI:   gain_i = data;
            CFG_KD:   gain_d = data;
            CFG_DT:   dt_val = data[DT_W-1:0];
            CFG_RATE: rate_val = data;
            default: ;
        endcase
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] dt,
                              input logic [GAIN_W-1:0] rate);
        write_reg(CFG_KP, kp);
        write_reg(CFG_SPARE_A, GAIN_W'($urandom));
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_DT, dt);
        write_reg(CFG_SPARE_B, GAIN_W'($urandom));
        write_reg(CFG_RATE, rate);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(input logic req, input logic [JSEL_W-1:0] jsel,
                             input logic signed [ANG_IN_W-1:0] ang,
                             input logic known, input joint_update_t known_result);
        int            gap;
        joint_update_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_joint_select <= jsel;
        s_angle_value  <= ang;
        do @(posedge aclk); while (!s_ready);
        predicted = pid_advance(req, jsel, ang);
        pending_updates.push_back(known ? known_result : predicted);
    endtask

    // mostly steps, about half toward a slowly moving per-joint aim; some presets and noise
    task automatic run_random(input int count);
        logic                       req;
        logic [JSEL_W-1:0]          jsel;
        logic signed [ANG_IN_W-1:0] ang;
        int                         r;
        repeat (count) begin
            if ($urandom_range(0, 99) < 5)
                jsel = JSEL_W'($urandom_range(JOINTS, 7));
            else
                jsel = JSEL_W'($urandom_range(0, JOINTS - 1));
            req = ($urandom_range(0, 99) < 8) ? REQ_PRESET : REQ_STEP;
            if (jsel < JOINTS && $urandom_range(0, 9) == 0)
                aim[jsel] = ANG_IN_W'(int'($urandom_range(0, 2 * ANG_LIMIT)) - ANG_LIMIT);
            r = $urandom_range(0, 99);
            if (r < 50 && jsel < JOINTS)
                ang = aim[jsel] + ANG_IN_W'(int'($urandom_range(0, 128)) - 64);
            else if (r < 80)
                ang = ANG_IN_W'(int'($urandom_range(0, 2 * ANG_LIMIT)) - ANG_LIMIT);
            else
                ang = ANG_IN_W'($urandom);
            send_item(req, jsel, ang, 1'b0, '0);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int ph;
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wr_data    <= '0;
        s_valid        <= 1'b0;
        s_req_type     <= REQ_STEP;
        s_joint_select <= '0;
        s_angle_value  <= '0;
        idle_mode       = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i].req, dir_tab[i].joint, dir_tab[i].ang,
                      dir_tab[i].known, dir_tab[i].want);
        settle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    idle_mode = 1;
                    load_gains(RST_KP, RST_KI, RST_KD, GAIN_W'(RST_DT), RST_RATE);
                end
                1: begin
                    idle_mode = 2;
                    load_gains('0, '0, '0, '0, '0);
                end
                2: begin
                    // dt data above bit 16 must be dropped
                    idle_mode = 0;
                    load_gains('1, '1, '1, '1, '1);
                end
                4: begin
                    idle_mode = 2;
                    load_gains(24'h01_0000, pick_gain(), pick_gain(), 24'h01_0000, 24'h01_0000);
                end
                6: begin
                    idle_mode = 2;
                    load_gains(RST_KP, RST_KI, RST_KD, GAIN_W'(RST_DT), RST_RATE);
                end
                default: begin
                    idle_mode = (ph == 5) ? 0 : 1;
                    load_gains(pick_gain(), pick_gain(), pick_gain(),
                               GAIN_W'($urandom_range(0, 65536)), pick_gain());
                end
            endcase
            run_random(PHASE_ITEMS);
            settle();
        end

        if (error_count == 0 && pending_updates.size() == 0)
            $display("multi_joint_pid_axis_test passed");
        else
            $display("multi_joint_pid_axis_test failed");
        $finish;
    end

    initial begin : result_ready
        int n;
        m_ready <= 1'b0;
        held_off = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            // one long hold-off so the block backs up into its input
            if (!held_off && beats_out >= 250) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        joint_update_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (pending_updates.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("beat %0d: unexpected result joint %0d vel %0d ang %0d sat %0b",
                             beats_out, m_joint_echo, m_drive_velocity, m_joint_angle,
                             m_saturated);
            end else begin
                want = pending_updates.pop_front();
                if (m_joint_echo !== want.joint || m_drive_velocity !== want.velocity ||
                    m_joint_angle !== want.angle || m_saturated !== want.clipped) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("beat %0d: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 beats_out, want.joint, want.velocity, want.angle,
                                 want.clipped, m_joint_echo, m_drive_velocity,
                                 m_joint_angle, m_saturated);
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("multi_joint_pid_axis_test failed");
        $finish;
    end

endmodule
